// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL modules (included by kmst_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== sv/kmst_pkg.sv =====
// Types and constants for the union-find spanning tree block.
`timescale 1ns / 1ps
package kmst_pkg;
  localparam int MAX_NODES_DEF  = 1024;
  localparam int NODE_FIELD_W   = 10;
  localparam int WEIGHT_W       = 20;
  localparam int COUNT_W        = 11;
  localparam int COST_W         = 32;
  localparam int RANK_W         = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 40;
  localparam int CFG_ADDR_W     = 3;
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic                    start;
    logic                    in_range;
    logic [NODE_FIELD_W-1:0] node_a;
    logic [NODE_FIELD_W-1:0] node_b;
    logic [WEIGHT_W-1:0]     weight;
  } cmd_t;
endpackage

// ===== sv/kruskal_union_find_mst.sv =====
// Top level: config register, edge queue front end and union-find back end.
//
//  port group | dir | payload
//  in_*       | in  | tuser: start_graph; tdata: node_a, node_b, weight
//  out_*      | out | tdata: accepted, total_cost, tree_complete
//  cfg_*      | in  | APB register 0 (byte 0): node_count
//
// After reset the forest memory is swept one entry a cycle through all MAX_NODES entries,
// and an edge with start_graph set costs the same sweep before it is handled.
// An in-range edge runs a find on each endpoint: each find walks the chain to the root,
// then walks it again to compress it, one memory read per cycle, and a union follows;
// a rank tie adds a second write (ST_UNION2), and an ignored edge goes straight to the result.
// Edges queue two deep at the input. A result waiting in the output register holds
// the back end, while the queue keeps accepting until it is full.
`timescale 1ns / 1ps
module kruskal_union_find_mst import kmst_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // [9:0] node_a, [19:10] node_b, [39:20] weight
  input  logic                   in_tuser,  // [0] start_graph
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // [0] accepted, [32:1] total_cost, [33] tree_complete
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  logic [COUNT_W-1:0] node_count_r, node_count_nxt;
  logic [COUNT_W-1:0] eff_n;
  logic               q_valid, q_pop;
  cmd_t               q_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-COUNT_W){1'b0}}, node_count_r};

  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == REG_NODE_COUNT)
      node_count_nxt = cfg_pwdata[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= NODE_COUNT_RST;
    else        node_count_r <= node_count_nxt;
  end

  // clamp to at least one node and at most the forest size
  always_comb begin
    if (node_count_r == '0)
      eff_n = COUNT_W'(1);
    else if (int'(node_count_r) > MAX_NODES)
      eff_n = COUNT_W'(MAX_NODES);
    else
      eff_n = node_count_r;
  end

  kmst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_n    (eff_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  kmst_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_n     (eff_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );
endmodule

// ===== sv/kmst_front.sv =====
// Input side: classifies edge requests and queues them for the back end.
`timescale 1ns / 1ps
module kmst_front import kmst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COUNT_W-1:0]    eff_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,  // node_a, node_b, weight
  input  logic                  in_tuser,  // start_graph
  output logic                  q_valid,
  output cmd_t                  q_cmd,
  input  logic                  q_pop
);
  cmd_t       slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.start    = in_tuser;
    cmd_in.node_a   = in_tdata[9:0];
    cmd_in.node_b   = in_tdata[19:10];
    cmd_in.weight   = in_tdata[39:20];
    cmd_in.in_range = ({1'b0, in_tdata[9:0]} < eff_n) && ({1'b0, in_tdata[19:10]} < eff_n);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== sv/kmst_back.sv =====
// Back end: forest memory, find with path compression, union by rank.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kmst_back import kmst_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COUNT_W-1:0]     eff_n,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata  // accepted, total_cost, tree_complete
);
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ENT_W  = RANK_W + NODE_W;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_FIND   = 8'b0000_1000,
    ST_COMP   = 8'b0001_0000,
    ST_UNION  = 8'b0010_0000,
    ST_UNION2 = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  logic [ENT_W-1:0] mem [MAX_NODES];
  logic [ENT_W-1:0] rdata_r;
  logic [NODE_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic              wr_en;

  state_t              state_r, state_nxt;
  logic                pend_r, pend_nxt;
  logic [NODE_W-1:0]   clr_r, clr_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt, root_r, root_nxt, ra_r, ra_nxt;
  logic [RANK_W-1:0]   rk_r, rk_nxt, rka_r, rka_nxt;
  logic                sel_r, sel_nxt, acc_r, acc_nxt;
  logic [COUNT_W-1:0]  edges_r, edges_nxt;
  logic [COST_W-1:0]   cost_r, cost_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [NODE_W-1:0] ent_parent, idx_a, idx_b;
  logic [RANK_W-1:0] ent_rank;
  logic [COST_W:0]   cost_sum;
  logic              complete;

  assign ent_parent = rdata_r[NODE_W-1:0];
  assign ent_rank   = rdata_r[ENT_W-1:NODE_W];
  assign idx_a      = NODE_W'(cmd_r.node_a);
  assign idx_b      = NODE_W'(cmd_r.node_b);
  assign cost_sum   = {1'b0, cost_r} + {{(COST_W+1-WEIGHT_W){1'b0}}, cmd_r.weight};
  assign complete   = (edges_r >= eff_n - 11'd1);

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    rk_nxt        = rk_r;
    rka_nxt       = rka_r;
    sel_nxt       = sel_r;
    acc_nxt       = acc_r;
    edges_nxt     = edges_r;
    cost_nxt      = cost_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    rd_addr       = cur_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = {ent_rank, root_r};
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = {{RANK_W{1'b0}}, clr_r};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NODE_W'(MAX_NODES - 1)) begin
          state_nxt = pend_r ? ST_CHECK : ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.start) begin
            // wipe the forest before this edge is handled
            state_nxt = ST_CLEAR;
            pend_nxt  = 1'b1;
            clr_nxt   = '0;
            edges_nxt = '0;
            cost_nxt  = '0;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (cmd_r.in_range && (edges_r < eff_n - 11'd1)) begin
          cur_nxt   = idx_a;
          rd_addr   = idx_a;
          sel_nxt   = 1'b0;
          state_nxt = ST_FIND;
        end else begin
          acc_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_FIND: begin
        if (ent_parent == cur_r) begin
          root_nxt  = cur_r;
          rk_nxt    = ent_rank;
          cur_nxt   = sel_r ? idx_b : idx_a;
          rd_addr   = sel_r ? idx_b : idx_a;
          state_nxt = ST_COMP;
        end else begin
          cur_nxt = ent_parent;
          rd_addr = ent_parent;
        end
      end
      ST_COMP: begin
        if (cur_r == root_r) begin
          if (!sel_r) begin
            ra_nxt    = root_r;
            rka_nxt   = rk_r;
            sel_nxt   = 1'b1;
            cur_nxt   = idx_b;
            rd_addr   = idx_b;
            state_nxt = ST_FIND;
          end else begin
            state_nxt = ST_UNION;
          end
        end else begin
          // point this node straight at the root, keep its rank
          wr_en   = 1'b1;
          wr_addr = cur_r;
          wr_data = {ent_rank, root_r};
          cur_nxt = ent_parent;
          rd_addr = ent_parent;
        end
      end
      ST_UNION: begin
        state_nxt = ST_DONE;
        if (ra_r == root_r) begin
          acc_nxt = 1'b0;
        end else begin
          acc_nxt   = 1'b1;
          edges_nxt = edges_r + 11'd1;
          cost_nxt  = cost_sum[COST_W] ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];
          wr_en     = 1'b1;
          if (rk_r > rka_r) begin
            wr_addr = ra_r;
            wr_data = {rka_r, root_r};
          end else begin
            wr_addr = root_r;
            wr_data = {rk_r, ra_r};
            if (rk_r == rka_r) state_nxt = ST_UNION2;
          end
        end
      end
      ST_UNION2: begin
        wr_en     = 1'b1;
        wr_addr   = ra_r;
        wr_data   = {(rka_r == RANK_MAX) ? RANK_MAX : rka_r + 1'b1, ra_r};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_TDATA_W-COST_W-2){1'b0}}, complete, cost_r, acc_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    ra_r       <= ra_nxt;
    rk_r       <= rk_nxt;
    rka_r      <= rka_nxt;
    sel_r      <= sel_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pend_r      <= 1'b0;
      clr_r       <= '0;
      edges_r     <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      clr_r       <= clr_nxt;
      edges_r     <= edges_nxt;
      cost_r      <= cost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_NEVER(a_pop_busy, q_pop && (state_r != ST_IDLE))
  `ASSERT_PROP(a_start_clears, (q_pop && q_cmd.start) |=> (state_r == ST_CLEAR && edges_r == '0))
  `ASSERT_PROP(a_tie_follows_union, (state_r == ST_UNION2) |-> ($past(state_r) == ST_UNION))
  `ASSERT_NEVER(a_write_idle, wr_en && (state_r == ST_IDLE || state_r == ST_DONE))
endmodule

// ===== sim/tb_mst_checker.sv =====
// Checker for the spanning tree block: predicts each result and compares it on the output.
`timescale 1ns / 1ps
module tb_mst_checker import kmst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     pending,
  output int                     fail_count
);
  localparam int NODES = MAX_NODES_DEF;

  typedef struct packed {
    logic              accepted;
    logic [COST_W-1:0] total_cost;
    logic              tree_complete;
  } mst_result_t;

  logic [NODE_FIELD_W-1:0] parent_of [NODES];
  logic [RANK_W-1:0]       set_rank  [NODES];
  logic [COUNT_W-1:0]      node_count;
  int unsigned             edges_taken;
  logic [COST_W-1:0]       cost_sum;
  mst_result_t             mst_expect_q[$];

  assign pending = mst_expect_q.size();

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic void clear_forest();
    for (int i = 0; i < NODES; i++) begin
      parent_of[i] = NODE_FIELD_W'(i);
      set_rank[i]  = '0;
    end
    edges_taken = 0;
    cost_sum    = '0;
  endfunction

  function automatic logic [NODE_FIELD_W-1:0] find_root(input logic [NODE_FIELD_W-1:0] x);
    logic [NODE_FIELD_W-1:0] root, cur, nxt;
    int k;
    root = x;
    k = 0;
    while (k < NODES && parent_of[root] != root) begin
      root = parent_of[root];
      k++;
    end
    // compress the whole walked path onto the root
    cur = x;
    while (cur != root) begin
      nxt = parent_of[cur];
      parent_of[cur] = root;
      cur = nxt;
    end
    return root;
  endfunction

  function automatic mst_result_t predict_edge(input logic start, input logic [IN_TDATA_W-1:0] d);
    mst_result_t r;
    int unsigned n;
    logic [NODE_FIELD_W-1:0] a, b, ra, rb;
    logic [WEIGHT_W-1:0] w;
    logic [COST_W:0] sum;
    if (start) clear_forest();
    n = (node_count == 0) ? 1 : (node_count > NODES) ? NODES : node_count;
    a = d[9:0];
    b = d[19:10];
    w = d[39:20];
    r = '0;
    if (edges_taken < n - 1 && a < n && b < n) begin
      ra = find_root(a);
      rb = find_root(b);
      if (ra != rb) begin
        r.accepted = 1'b1;
        edges_taken++;
        sum = {1'b0, cost_sum} + w;
        cost_sum = sum[COST_W] ? '1 : sum[COST_W-1:0];
        if (set_rank[ra] > set_rank[rb]) parent_of[rb] = ra;
        else if (set_rank[rb] > set_rank[ra]) parent_of[ra] = rb;
        else begin
          parent_of[rb] = ra;
          if (set_rank[ra] != RANK_MAX) set_rank[ra]++;
        end
      end
    end
    r.total_cost    = cost_sum;
    r.tree_complete = (edges_taken >= n - 1);
    return r;
  endfunction

  always @(posedge clk) begin
    mst_result_t exp_r;
    if (!rst_n) begin
      node_count = NODE_COUNT_RST;
      clear_forest();
      mst_expect_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == CFG_ADDR_W'({REG_NODE_COUNT, 2'b00}))
        node_count = cfg_pwdata[COUNT_W-1:0];
      if (in_tvalid && in_tready)
        mst_expect_q.insert(mst_expect_q.size(), predict_edge(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (mst_expect_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          exp_r = mst_expect_q.pop_front();
          if (out_tdata[0] !== exp_r.accepted)
            report_mismatch($sformatf("accepted %0b, want %0b", out_tdata[0], exp_r.accepted));
          if (out_tdata[32:1] !== exp_r.total_cost)
            report_mismatch($sformatf("total_cost %0d, want %0d", out_tdata[32:1],
                                      exp_r.total_cost));
          if (out_tdata[33] !== exp_r.tree_complete)
            report_mismatch($sformatf("tree_complete %0b, want %0b", out_tdata[33],
                                      exp_r.tree_complete));
        end
      end
    end
  end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives edges and node_count settings into the block and gives the verdict.
`timescale 1ns / 1ps
module tb_top import kmst_pkg::*;;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // [9:0] node_a, [19:10] node_b, [39:20] weight
  logic in_tuser = 1'b0;                  // [0] start_graph
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [0] accepted, [32:1] total_cost, [33] tree_complete
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int pending, fail_count;
  int results_seen = 0;

  always #2 clk = ~clk;

  kruskal_union_find_mst uut (.*);

  tb_mst_checker chk (.*);

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, with two long hold-offs to back up the input queue
  initial begin
    int gap;
    @(posedge clk);
    while (rst_n == 1'b0) @(posedge clk);
    forever begin
      if (results_seen == 250 || results_seen == 900) gap = 400;
      else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
    end
  end

  task automatic send_edge(input logic start, input logic [9:0] a, input logic [9:0] b,
                           input logic [19:0] w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {w, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'({REG_NODE_COUNT, 2'b00});
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int settings[10] = '{1024, 0, 1, 2, 3, 7, 16, 2047, 40, 100};
    int n, eff, len, glen;
    logic [19:0] w;
    logic [9:0] a, b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default node_count of 1024
    send_edge(1'b0, 10'd0, 10'd1023, 20'd0);
    send_edge(1'b0, 10'd1023, 10'd0, 20'd1);
    send_edge(1'b0, 10'd5, 10'd5, 20'd2);
    send_edge(1'b0, 10'd1023, 10'd512, 20'hFFFFF);
    send_edge(1'b1, 10'd1023, 10'd0, 20'hFFFFF);
    send_edge(1'b0, 10'd682, 10'd341, 20'hFFFFF);
    drain();
    // two nodes: complete tree, then ignored and out-of-range edges
    write_node_count(32'd2);
    send_edge(1'b1, 10'd1, 10'd0, 20'd7);
    send_edge(1'b0, 10'd0, 10'd1, 20'd8);
    send_edge(1'b1, 10'd2, 10'd0, 20'd9);
    send_edge(1'b0, 10'd1, 10'd1023, 20'd9);
    send_edge(1'b0, 10'd0, 10'd1, 20'd10);
    drain();
    // zero acts as one node: tree complete from the start
    write_node_count(32'd0);
    send_edge(1'b1, 10'd0, 10'd0, 20'd3);
    send_edge(1'b0, 10'd0, 10'd1, 20'd3);
    drain();
    // above the maximum acts as the maximum; shrink mid-graph afterwards
    write_node_count(32'hFFFF_FFFF);
    send_edge(1'b1, 10'd1023, 10'd1022, 20'd4);
    send_edge(1'b0, 10'd3, 10'd4, 20'd5);
    send_edge(1'b0, 10'd1022, 10'd4, 20'd6);
    drain();
    write_node_count(32'd3);
    send_edge(1'b0, 10'd0, 10'd1, 20'd6);
    drain();

    foreach (settings[i]) begin
      write_node_count(settings[i]);
      n = settings[i];
      eff = (n == 0) ? 1 : (n > 1024) ? 1024 : n;
      len = 0;
      while (len < 130) begin
        if ($urandom_range(0, 9) < 8) begin
          // graph from scratch, endpoints in range, non-decreasing weights
          w = 20'($urandom_range(0, 1000));
          glen = $urandom_range(4, 40);
          for (int k = 0; k < glen && len < 130; k++) begin
            a = 10'((eff > 24 && $urandom_range(0, 1)) ? $urandom_range(0, 23)
                                                       : $urandom_range(0, eff - 1));
            b = 10'((eff > 24 && $urandom_range(0, 1)) ? $urandom_range(0, 23)
                                                       : $urandom_range(0, eff - 1));
            send_edge(k == 0, a, b, w);
            w = (w > 20'hFFFFF - 20'd30000) ? 20'hFFFFF
                                            : 20'(w + $urandom_range(0, 30000));
            len++;
          end
        end else begin
          // noise: any endpoints and weights, rare restarts
          for (int k = 0; k < 6; k++) begin
            send_edge($urandom_range(0, 20) == 0, 10'($urandom), 10'($urandom),
                      20'($urandom));
            len++;
          end
        end
      end
      drain();
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
